### rtl/vspd_pkg.sv
// Shared types, widths and register codes for the vehicle speed PI drive.
// No dependencies; imported by every module of the block.
package vspd_pkg;

   localparam int ERR_W   = 17;  // speed or yaw error, signed
   localparam int MUL_A_W = 18;  // shared multiplier, narrow operand
   localparam int MUL_B_W = 35;  // shared multiplier, wide operand
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int INT_W   = 40;  // error integral
   localparam int ACC_W   = 52;  // PI sum before clamping
   localparam int ADDR_W  = 5;

   typedef enum logic [2:0] {
      REG_SPEED_GAIN     = 3'd0,
      REG_INTEGRAL_GAIN  = 3'd1,
      REG_INTEGRAL_LIMIT = 3'd2,
      REG_YAW_GAIN       = 3'd3,
      REG_REVERSE_ENABLE = 3'd4
   } reg_idx_type;

   typedef struct packed {
      logic [15:0] speed_gain;
      logic [15:0] integral_gain;
      logic [31:0] integral_limit;
      logic [15:0] yaw_gain;
      logic        reverse_enable;
   } cfg_type;

endpackage

### rtl/vspd_csr.sv
// APB register file for the drive gains, integral limit and reverse enable.
// Depends on vspd_pkg for the register codes and the cfg_type struct.
module vspd_csr
   import vspd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign idx    = reg_idx_type'(paddr[ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_SPEED_GAIN:     cfg_in.speed_gain     = pwdata[15:0];
            REG_INTEGRAL_GAIN:  cfg_in.integral_gain  = pwdata[15:0];
            REG_INTEGRAL_LIMIT: cfg_in.integral_limit = pwdata;
            REG_YAW_GAIN:       cfg_in.yaw_gain       = pwdata[15:0];
            REG_REVERSE_ENABLE: cfg_in.reverse_enable = pwdata[0];
            default:            cfg_in = cfg_ff;  // unmapped: ignored
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_SPEED_GAIN:     prdata = {16'd0, cfg_ff.speed_gain};
         REG_INTEGRAL_GAIN:  prdata = {16'd0, cfg_ff.integral_gain};
         REG_INTEGRAL_LIMIT: prdata = cfg_ff.integral_limit;
         REG_YAW_GAIN:       prdata = {16'd0, cfg_ff.yaw_gain};
         REG_REVERSE_ENABLE: prdata = {31'd0, cfg_ff.reverse_enable};
         default:            prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_gain     <= 16'd0;
         cfg_ff.integral_gain  <= 16'd0;
         cfg_ff.integral_limit <= 32'd0;
         cfg_ff.yaw_gain       <= 16'd0;
         cfg_ff.reverse_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/vspd_mul.sv
// Shared signed multiplier with a registered product.
// Depends on vspd_pkg for the operand widths.
module vspd_mul
   import vspd_pkg::*;
(
   input  logic                      clock,
   input  logic signed [MUL_A_W-1:0] mul_a,
   input  logic signed [MUL_B_W-1:0] mul_b,
   output logic signed [PROD_W-1:0]  prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

### rtl/vehicle_speed_pi_drive.sv
// Top level of the vehicle speed PI drive: sequencer and datapath around one
// shared multiplier. Depends on vspd_pkg, vspd_csr and vspd_mul.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  req     | in        | req_valid/req_ready  | restart, speeds, yaw, gear, dt
//  rsp     | out       | rsp_valid/rsp_ready  | steering, throttle, brake, gear
//  csr     | in/out    | APB, pready tied high| gains, limit, reverse enable
//
// Each request makes four passes through the shared multiplier in sequence
// (S_ED, S_INT, S_PI, S_ACC), then the output step S_OUT registers the result.
// req_ready is high only while the sequencer is idle, so the next request is
// taken only after the last has left S_OUT. A result waiting in the output
// register holds the sequencer in its last step until it is taken. Reset is
// synchronous: clears sequencer, integral and CSRs, but sets reverse enable.
module vehicle_speed_pi_drive
   import vspd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_restart,
   input  logic signed [15:0] req_target_speed,
   input  logic signed [15:0] req_measured_speed,
   input  logic signed [15:0] req_target_yaw_rate,
   input  logic signed [15:0] req_measured_yaw_rate,
   input  logic signed [3:0]  req_current_gear,
   input  logic [15:0]       req_time_step,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic signed [15:0] rsp_steering,
   output logic [14:0]       rsp_throttle,
   output logic [14:0]       rsp_brake,
   output logic [1:0]        rsp_gear_request,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   typedef enum logic [2:0] {
      S_IDLE, S_ED, S_INT, S_PI, S_ACC, S_OUT
   } state_type;

   cfg_type cfg;

   state_type                state_ff, state_in;
   logic signed [INT_W-1:0]  integral_ff, integral_in;
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic signed [ERR_W-1:0]  yerr_ff, yerr_in;
   logic [15:0]              dt_ff, dt_in;
   logic                     ms_neg_ff, ms_neg_in;
   logic                     ms_pos_ff, ms_pos_in;
   logic                     gear_neg_ff, gear_neg_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]       steer_ff, steer_in;
   logic [14:0]              thr_ff, thr_in;
   logic [14:0]              brk_ff, brk_in;
   logic [1:0]               greq_ff, greq_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;

   logic signed [INT_W:0]    int_sum, lim_pos, lim_neg;
   logic signed [33:0]       acc_cl;
   logic [32:0]              acc_abs;
   logic [15:0]              mag_raw;
   logic [14:0]              mag;
   logic                     acc_gt0;
   logic signed [17:0]       s_cl, s_half;
   logic signed [15:0]       steer_val;
   logic                     out_free;

   vspd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   vspd_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_steering     = steer_ff;
   assign rsp_throttle     = thr_ff;
   assign rsp_brake        = brk_ff;
   assign rsp_gear_request = greq_ff;
   assign out_free         = !rsp_valid_ff || rsp_ready;

   // integral update: add the error step, then clamp to the symmetric limit
   assign lim_pos = $signed({9'd0, cfg.integral_limit});
   assign lim_neg = -lim_pos;
   assign int_sum = {integral_ff[INT_W-1], integral_ff} + prod[INT_W:0];

   // PI sum clamped to plus or minus one (2^32), magnitude in unsigned Q0.15
   always_comb begin
      if (acc_ff > $signed(ACC_W'(64'sd4294967296)))
         acc_cl = 34'sd4294967296;
      else if (acc_ff < -$signed(ACC_W'(64'sd4294967296)))
         acc_cl = -34'sd4294967296;
      else
         acc_cl = acc_ff[33:0];
      acc_abs = acc_cl[33] ? 33'(-acc_cl) : acc_cl[32:0];
      mag_raw = acc_abs[32:17];
      mag     = mag_raw[15] ? 15'h7fff : mag_raw[14:0];
      acc_gt0 = !acc_ff[ACC_W-1] && (acc_ff != '0);
   end

   // steering: clamp, halve towards zero, saturate to plus or minus 32767
   always_comb begin
      if (prod > $signed(PROD_W'(65536)))
         s_cl = 18'sd65536;
      else if (prod < -$signed(PROD_W'(65536)))
         s_cl = -18'sd65536;
      else
         s_cl = prod[17:0];
      s_half = (s_cl + $signed({17'd0, s_cl[17]})) >>> 1;
      if (s_half > 18'sd32767)
         steer_val = 16'sd32767;
      else if (s_half < -18'sd32767)
         steer_val = -16'sd32767;
      else
         steer_val = s_half[15:0];
   end

   always_comb begin
      state_in     = state_ff;
      integral_in  = integral_ff;
      err_in       = err_ff;
      yerr_in      = yerr_ff;
      dt_in        = dt_ff;
      ms_neg_in    = ms_neg_ff;
      ms_pos_in    = ms_pos_ff;
      gear_neg_in  = gear_neg_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      steer_in     = steer_ff;
      thr_in       = thr_ff;
      brk_in       = brk_ff;
      greq_in      = greq_ff;
      mul_a        = '0;
      mul_b        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               err_in      = ERR_W'(req_target_speed) - ERR_W'(req_measured_speed);
               yerr_in     = ERR_W'(req_target_yaw_rate) - ERR_W'(req_measured_yaw_rate);
               dt_in       = req_time_step;
               ms_neg_in   = req_measured_speed[15];
               ms_pos_in   = !req_measured_speed[15] && (req_measured_speed != 16'sd0);
               gear_neg_in = req_current_gear[3];
               if (req_restart)
                  integral_in = '0;
               state_in = S_ED;
            end
         end
         S_ED: begin
            mul_a    = MUL_A_W'(err_ff);
            mul_b    = $signed({{(MUL_B_W-16){1'b0}}, dt_ff});
            state_in = S_INT;
         end
         S_INT: begin
            if (int_sum > lim_pos)
               integral_in = lim_pos[INT_W-1:0];
            else if (int_sum < lim_neg)
               integral_in = lim_neg[INT_W-1:0];
            else
               integral_in = int_sum[INT_W-1:0];
            mul_a    = $signed({2'b00, cfg.speed_gain});
            mul_b    = MUL_B_W'(err_ff);
            state_in = S_PI;
         end
         S_PI: begin
            acc_in   = {prod[35:0], 16'd0};
            mul_a    = $signed({2'b00, cfg.integral_gain});
            mul_b    = integral_ff[MUL_B_W-1:0];  // |I| < 2^32 fits
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in   = acc_ff + prod[ACC_W-1:0];
            mul_a    = $signed({2'b00, cfg.yaw_gain});
            mul_b    = MUL_B_W'(yerr_ff);
            state_in = S_OUT;
         end
         S_OUT: begin
            // product holds the yaw term until the output register frees up
            mul_a = $signed({2'b00, cfg.yaw_gain});
            mul_b = MUL_B_W'(yerr_ff);
            if (out_free) begin
               rsp_valid_in = 1'b1;
               steer_in     = steer_val;
               thr_in       = '0;
               brk_in       = '0;
               greq_in      = 2'd0;
               if (acc_gt0) begin
                  if (!ms_neg_ff && !gear_neg_ff) begin
                     thr_in = mag;
                  end else begin
                     greq_in = 2'd1;
                     brk_in  = mag;
                  end
               end else begin
                  if (ms_pos_ff || !cfg.reverse_enable) begin
                     brk_in = mag;
                  end else begin
                     greq_in = 2'd2;
                     thr_in  = mag;
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         integral_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         integral_ff  <= integral_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      err_ff      <= err_in;
      yerr_ff     <= yerr_in;
      dt_ff       <= dt_in;
      ms_neg_ff   <= ms_neg_in;
      ms_pos_ff   <= ms_pos_in;
      gear_neg_ff <= gear_neg_in;
      acc_ff      <= acc_in;
      steer_ff    <= steer_in;
      thr_ff      <= thr_in;
      brk_ff      <= brk_in;
      greq_ff     <= greq_in;
   end

`ifndef SYNTHESIS
   // integral stays inside the configured limit once clamped
   a_int_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PI) |->
         ($signed({integral_ff[INT_W-1], integral_ff}) <= lim_pos &&
          $signed({integral_ff[INT_W-1], integral_ff}) >= lim_neg))
      else $error("integral outside limit");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   a_thr_brk_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_throttle == 15'd0 || rsp_brake == 15'd0))
      else $error("throttle and brake both applied");

   a_gear_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_gear_request != 2'd3))
      else $error("invalid gear request");

   a_result_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_valid_ff && !rsp_ready) |=> (state_ff == S_OUT))
      else $error("result overwritten before being taken");
`endif

endmodule
